// ===== hw/rtl/bbad_pkg.sv =====
package bbad_pkg;

    localparam int QUEUE_DEPTH = 2048;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SIZE_W      = 31;
    localparam int OCC_W       = 33;
    localparam int ENTRIES_W   = 12;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 80;

    localparam logic [OCC_W-1:0] CAP_RESET = 33'h1_0000_0000;

    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_CAPACITY = 4'h0;

    localparam logic REQ_ADMIT = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        CT_IDLE,
        CT_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic              rd_en;
        logic              push;
        logic              pop;
        logic [SIZE_W-1:0] wdata;
    } q_cmd_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic [SIZE_W-1:0] rdata;
    } q_stat_t;

    // lowest bit is the last member
    typedef struct packed {
        logic                 pad;
        logic [ENTRIES_W-1:0] entries_out;
        logic [OCC_W-1:0]     occupancy_out;
        logic [SIZE_W-1:0]    drained_size;
        status_t              status_code;
        logic                 accepted;
    } result_t;

endpackage

// ===== hw/rtl/bbad_queue.sv =====
module bbad_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  bbad_pkg::q_cmd_t cmd,
    output bbad_pkg::q_stat_t stat
);

    logic [bbad_pkg::SIZE_W-1:0] pending_mem [bbad_pkg::QUEUE_DEPTH];
    logic [bbad_pkg::SIZE_W-1:0] rdata_reg;
    logic [bbad_pkg::QIDX_W-1:0] head_reg, head_next;
    logic [bbad_pkg::QIDX_W-1:0] tail_reg, tail_next;
    logic [bbad_pkg::QCNT_W-1:0] count_reg, count_next;

    localparam logic [bbad_pkg::QIDX_W-1:0] LAST_IDX =
        bbad_pkg::QIDX_W'(bbad_pkg::QUEUE_DEPTH - 1);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            pending_mem[tail_reg] <= cmd.wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= pending_mem[head_reg];
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.rdata = rdata_reg;

endmodule

// ===== hw/rtl/bbad_ctrl.sv =====
module bbad_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bbad_pkg::OCC_W-1:0]          capacity,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_req_type,
    input  logic [bbad_pkg::SIZE_W-1:0]         s_req_size,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output bbad_pkg::result_t                   m_result,
    output bbad_pkg::q_cmd_t                    q_cmd,
    input  bbad_pkg::q_stat_t                   q_stat
);

    bbad_pkg::ctrl_state_t state_reg, state_next;
    logic                          type_reg, type_next;
    logic [bbad_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [bbad_pkg::OCC_W-1:0]    occ_reg, occ_next;
    logic                          m_valid_reg, m_valid_next;
    bbad_pkg::result_t             res_reg, res_next;

    logic                          out_free;
    logic [bbad_pkg::OCC_W:0]      sum;
    logic [bbad_pkg::QCNT_W-1:0]   cnt_after;

    assign out_free = !m_valid_reg || m_tready;
    assign sum      = {1'b0, occ_reg} + {{(bbad_pkg::OCC_W + 1 - bbad_pkg::SIZE_W){1'b0}}, size_reg};

    always_comb begin
        state_next   = state_reg;
        type_next    = type_reg;
        size_next    = size_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_tready;
        res_next     = res_reg;
        s_tready     = 1'b0;
        q_cmd        = '0;
        q_cmd.wdata  = size_reg;
        cnt_after    = q_stat.count;
        case (state_reg)
            bbad_pkg::CT_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    q_cmd.rd_en = 1'b1;
                    type_next   = s_req_type;
                    size_next   = s_req_size;
                    state_next  = bbad_pkg::CT_EXEC;
                end
            end
            bbad_pkg::CT_EXEC: begin
                if (out_free) begin
                    res_next              = '0;
                    res_next.status_code  = bbad_pkg::ST_OK;
                    if (type_reg == bbad_pkg::REQ_ADMIT) begin
                        if (sum > {1'b0, capacity}) begin
                            res_next.status_code = bbad_pkg::ST_NO_SPACE;
                        end else if (q_stat.count >=
                                     bbad_pkg::QCNT_W'(bbad_pkg::QUEUE_DEPTH)) begin
                            res_next.status_code = bbad_pkg::ST_FULL;
                        end else begin
                            q_cmd.push        = 1'b1;
                            occ_next          = sum[bbad_pkg::OCC_W-1:0];
                            cnt_after         = q_stat.count + 1'b1;
                            res_next.accepted = 1'b1;
                        end
                    end else begin
                        if (q_stat.count == '0) begin
                            res_next.status_code = bbad_pkg::ST_EMPTY;
                        end else begin
                            q_cmd.pop             = 1'b1;
                            res_next.drained_size = q_stat.rdata;
                            occ_next = (occ_reg >= bbad_pkg::OCC_W'(q_stat.rdata)) ?
                                       occ_reg - bbad_pkg::OCC_W'(q_stat.rdata) : '0;
                            cnt_after             = q_stat.count - 1'b1;
                            res_next.accepted     = 1'b1;
                        end
                    end
                    res_next.occupancy_out = occ_next;
                    res_next.entries_out   = bbad_pkg::ENTRIES_W'(cnt_after);
                    m_valid_next           = 1'b1;
                    state_next             = bbad_pkg::CT_IDLE;
                end
            end
            default: begin
                state_next = bbad_pkg::CT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbad_pkg::CT_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        size_reg <= size_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;

    a_accept_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.accepted == (res_reg.status_code == bbad_pkg::ST_OK)))
        else $error("accepted flag disagrees with status");

    a_drained_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.accepted) |-> (res_reg.drained_size == '0))
        else $error("drained size nonzero on rejected request");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= bbad_pkg::QCNT_W'(bbad_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_queue_ops_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_cmd.push || q_cmd.pop) |-> (state_reg == bbad_pkg::CT_EXEC && out_free))
        else $error("queue update outside commit");

    a_occ_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbad_pkg::CT_IDLE) |=> (occ_reg == $past(occ_reg)))
        else $error("occupancy changed without a request");

endmodule

// ===== hw/rtl/burst_buffer_admission_drain.sv =====
// Admission control for a staging buffer with a queue of pending sizes.
// Input stream (s_*): one request per transfer. s_tuser is the request type
// (0 admit, 1 drain); s_tdata[30:0] is the admit size in bytes.
// Output stream (m_*): one result per request, in request order, carried in
// m_tdata: accepted, status, drained size, occupancy and queue entries.
// Configuration: APB port, 64-bit data; capacity_bytes at byte address 0.
// Writes must be made only while no request is in flight; the block does
// not enforce this. Timing: a request is taken in the idle state and its
// result is registered in the execute state, which waits for the output
// register to free; no new request is taken until then. The size memory is
// read at the head on every taken request and updated in the execute state.
// A finished result waits in the output register; the next request is still
// taken meanwhile, and the block holds it until the output register frees.
// Reset (aresetn low, synchronous): the queue is emptied, occupancy is
// cleared and the capacity returns to 4294967296 bytes. The size memory is
// not cleared; only entries written by admits are ever used.
module burst_buffer_admission_drain (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbad_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bbad_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bbad_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bbad_pkg::IN_DATA_W-1:0]      s_tdata,   // req_size[30:0], zero pad
    input  logic                                s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accepted[0], status_code[2:1], drained_size[33:3], occupancy_out[66:34],
    // entries_out[78:67], zero pad[79]
    output logic [bbad_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic [bbad_pkg::OCC_W-1:0] cap_reg;
    logic                       cfg_wr;
    bbad_pkg::q_cmd_t           q_cmd;
    bbad_pkg::q_stat_t          q_stat;
    bbad_pkg::result_t          result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr == bbad_pkg::CFG_ADDR_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bbad_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[bbad_pkg::OCC_W-1:0];
        end
    end

    assign prdata = (paddr == bbad_pkg::CFG_ADDR_CAPACITY) ?
                    bbad_pkg::CFG_DATA_W'(cap_reg) : '0;

    bbad_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity   (cap_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_req_type (s_tuser),
        .s_req_size (s_tdata[bbad_pkg::SIZE_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result),
        .q_cmd      (q_cmd),
        .q_stat     (q_stat)
    );

    bbad_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (q_cmd),
        .stat    (q_stat)
    );

    assign m_tdata = result;

endmodule

// ===== bench/tb_burst_buffer_admission_drain.sv =====
`timescale 1ns / 1ps

module tb_burst_buffer_admission_drain;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [bbad_pkg::SIZE_W-1:0] SIZE_MAX = '1;
    localparam logic [bbad_pkg::OCC_W-1:0] CAP_MAX = '1;
    localparam logic [bbad_pkg::CFG_ADDR_W-1:0] CFG_ADDR_UNMAPPED = 4'h8;

    logic                                aclk;
    logic                                aresetn = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [bbad_pkg::CFG_ADDR_W-1:0]     paddr = '0;
    logic [bbad_pkg::CFG_DATA_W-1:0]     pwdata = '0;
    logic [bbad_pkg::CFG_DATA_W-1:0]     prdata;
    logic                                pready;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [bbad_pkg::IN_DATA_W-1:0]      s_tdata = '0;    // req_size[30:0], zero pad[31]
    logic                                s_tuser = 1'b0;  // req_type
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    // accepted[0], status_code[2:1], drained_size[33:3], occupancy_out[66:34],
    // entries_out[78:67], zero pad[79]
    logic [bbad_pkg::OUT_DATA_W-1:0]     m_tdata;

    logic [bbad_pkg::SIZE_W-1:0]         pending_sizes_q[$];
    logic [bbad_pkg::OCC_W-1:0]          occupancy_m = '0;
    logic [bbad_pkg::OCC_W-1:0]          capacity_m = bbad_pkg::CAP_RESET;
    bbad_pkg::result_t                   results_due[$];

    bit                      no_idle = 1'b0;
    int                      err_count = 0;
    int                      sent_count = 0;
    int                      result_count = 0;
    int                      status_seen[4];
    int                      cycle_count = 0;
    int                      ready_stall = 0;

    burst_buffer_admission_drain uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_burst_buffer_admission_drain NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic bbad_pkg::result_t predict_request(
        logic kind, logic [bbad_pkg::SIZE_W-1:0] size);
        bbad_pkg::result_t           r;
        logic [bbad_pkg::OCC_W:0]    sum;
        logic [bbad_pkg::SIZE_W-1:0] popped;
        r = '0;
        r.status_code = bbad_pkg::ST_OK;
        if (kind == bbad_pkg::REQ_ADMIT) begin
            sum = {1'b0, occupancy_m} +
                  {{(bbad_pkg::OCC_W + 1 - bbad_pkg::SIZE_W){1'b0}}, size};
            if (sum > {1'b0, capacity_m}) begin
                r.status_code = bbad_pkg::ST_NO_SPACE;
            end else if (pending_sizes_q.size() >= bbad_pkg::QUEUE_DEPTH) begin
                r.status_code = bbad_pkg::ST_FULL;
            end else begin
                pending_sizes_q.push_back(size);
                occupancy_m = sum[bbad_pkg::OCC_W-1:0];
                r.accepted = 1'b1;
            end
        end else begin
            if (pending_sizes_q.size() == 0) begin
                r.status_code = bbad_pkg::ST_EMPTY;
            end else begin
                popped = pending_sizes_q.pop_front();
                r.drained_size = popped;
                occupancy_m = (occupancy_m >= popped) ? occupancy_m - popped : '0;
                r.accepted = 1'b1;
            end
        end
        r.occupancy_out = occupancy_m;
        r.entries_out = bbad_pkg::ENTRIES_W'(pending_sizes_q.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_stall > 0) begin
            ready_stall--;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            ready_stall = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bbad_pkg::result_t got;
        bbad_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = bbad_pkg::result_t'(m_tdata);
            result_count++;
            status_seen[got.status_code]++;
            if (results_due.size() == 0) begin
                $error("unexpected result transfer: %h", m_tdata);
                err_count++;
            end else begin
                want = results_due.pop_front();
                if (got.accepted !== want.accepted) begin
                    $error("accepted expected %0d got %0d", want.accepted, got.accepted);
                    err_count++;
                end
                if (got.status_code !== want.status_code) begin
                    $error("status_code expected %0d got %0d",
                           want.status_code, got.status_code);
                    err_count++;
                end
                if (got.drained_size !== want.drained_size) begin
                    $error("drained_size expected %0d got %0d",
                           want.drained_size, got.drained_size);
                    err_count++;
                end
                if (got.occupancy_out !== want.occupancy_out) begin
                    $error("occupancy_out expected %0d got %0d",
                           want.occupancy_out, got.occupancy_out);
                    err_count++;
                end
                if (got.entries_out !== want.entries_out) begin
                    $error("entries_out expected %0d got %0d",
                           want.entries_out, got.entries_out);
                    err_count++;
                end
            end
        end
    end

    task automatic send_request(input logic kind, input logic [bbad_pkg::SIZE_W-1:0] size);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, size};
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(predict_request(kind, size));
        sent_count++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_capacity_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= bbad_pkg::CFG_ADDR_CAPACITY;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[bbad_pkg::OCC_W-1:0] !== capacity_m) begin
            $error("capacity_bytes expected %0d got %0d",
                   capacity_m, prdata[bbad_pkg::OCC_W-1:0]);
            err_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [bbad_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [bbad_pkg::CFG_DATA_W-1:0] value);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == bbad_pkg::CFG_ADDR_CAPACITY)
            capacity_m = value[bbad_pkg::OCC_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        check_capacity_readback();
    endtask

    task automatic drain_until_empty();
        while (pending_sizes_q.size() != 0)
            send_request(bbad_pkg::REQ_DRAIN, bbad_pkg::SIZE_W'($urandom));
        send_request(bbad_pkg::REQ_DRAIN, bbad_pkg::SIZE_W'($urandom));
    endtask

    task automatic test_reset_capacity();
        check_capacity_readback();
        send_request(bbad_pkg::REQ_DRAIN, SIZE_MAX);
        send_request(bbad_pkg::REQ_ADMIT, '0);
        send_request(bbad_pkg::REQ_ADMIT, SIZE_MAX);
        send_request(bbad_pkg::REQ_ADMIT, SIZE_MAX);
        send_request(bbad_pkg::REQ_ADMIT, SIZE_MAX);
        send_request(bbad_pkg::REQ_ADMIT, 31'd2);
        send_request(bbad_pkg::REQ_ADMIT, '0);
        send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        drain_until_empty();
    endtask

    task automatic test_capacity_lowered();
        send_request(bbad_pkg::REQ_ADMIT, 31'd1000);
        send_request(bbad_pkg::REQ_ADMIT, 31'd500);
        write_register(bbad_pkg::CFG_ADDR_CAPACITY, 64'd800);
        send_request(bbad_pkg::REQ_ADMIT, '0);
        send_request(bbad_pkg::REQ_DRAIN, '0);
        send_request(bbad_pkg::REQ_ADMIT, '0);
        write_register(CFG_ADDR_UNMAPPED, 64'd5);
        send_request(bbad_pkg::REQ_ADMIT, 31'd300);
        send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        drain_until_empty();
    endtask

    task automatic test_capacity_extremes();
        write_register(bbad_pkg::CFG_ADDR_CAPACITY, '0);
        send_request(bbad_pkg::REQ_ADMIT, '0);
        send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        drain_until_empty();
        write_register(bbad_pkg::CFG_ADDR_CAPACITY,
                       {{(bbad_pkg::CFG_DATA_W - bbad_pkg::OCC_W){1'b0}}, CAP_MAX});
        repeat (4) send_request(bbad_pkg::REQ_ADMIT, SIZE_MAX);
        send_request(bbad_pkg::REQ_ADMIT, 31'd3);
        send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        drain_until_empty();
    endtask

    task automatic test_queue_full();
        write_register(bbad_pkg::CFG_ADDR_CAPACITY,
                       {{(bbad_pkg::CFG_DATA_W - bbad_pkg::OCC_W){1'b0}},
                        bbad_pkg::CAP_RESET});
        repeat (bbad_pkg::QUEUE_DEPTH) send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        write_register(bbad_pkg::CFG_ADDR_CAPACITY,
                       bbad_pkg::CFG_DATA_W'(bbad_pkg::QUEUE_DEPTH));
        send_request(bbad_pkg::REQ_ADMIT, 31'd1);
        send_request(bbad_pkg::REQ_ADMIT, '0);
        drain_until_empty();
    endtask

    function automatic logic [bbad_pkg::SIZE_W-1:0] random_size(bit small_only);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (small_only || r < 55)
            return bbad_pkg::SIZE_W'($urandom_range(0, 4095));
        if (r < 65)
            return SIZE_MAX;
        return bbad_pkg::SIZE_W'($urandom);
    endfunction

    task automatic run_random_phase(input logic [bbad_pkg::OCC_W-1:0] capacity,
                                    input bit small_only, input int count);
        write_register(bbad_pkg::CFG_ADDR_CAPACITY,
                       {{(bbad_pkg::CFG_DATA_W - bbad_pkg::OCC_W){1'b0}}, capacity});
        repeat (count) begin
            if ($urandom_range(0, 99) < 55)
                send_request(bbad_pkg::REQ_ADMIT, random_size(small_only));
            else
                send_request(bbad_pkg::REQ_DRAIN, bbad_pkg::SIZE_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(bbad_pkg::CAP_RESET, 1'b0, 100);
        run_random_phase(bbad_pkg::OCC_W'($urandom_range(1000, 200000)), 1'b1, 100);
        no_idle = 1'b1;
        run_random_phase(CAP_MAX, 1'b0, 100);
        no_idle = 1'b0;
        run_random_phase({1'($urandom_range(0, 1)), 32'($urandom)}, 1'b0, 100);
        drain_until_empty();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_capacity();
        test_capacity_lowered();
        test_capacity_extremes();
        test_queue_full();
        test_random_traffic();
        settle();
        repeat (10) @(posedge aclk);
        $display("sent %0d requests, checked %0d results", sent_count, result_count);
        $display("status counts: ok %0d, no space %0d, queue full %0d, queue empty %0d",
                 status_seen[bbad_pkg::ST_OK], status_seen[bbad_pkg::ST_NO_SPACE],
                 status_seen[bbad_pkg::ST_FULL], status_seen[bbad_pkg::ST_EMPTY]);
        if (err_count == 0 && results_due.size() == 0)
            $display("tb_burst_buffer_admission_drain OK");
        else
            $display("tb_burst_buffer_admission_drain NOT OK");
        $finish;
    end

endmodule
